FILE: src/xfsc_pkg.sv
// shared types, constants and helper functions of the crossfade switch controller
`timescale 1ns / 1ps
`default_nettype none
package xfsc_pkg;

  localparam int SLOT_W = 4;
  localparam int SLOT_N = 2 ** SLOT_W;
  localparam int MASK_W = 12;
  localparam int DUR_W  = 16;
  localparam int TICK_W = 16;
  localparam int REQ_W  = 8;
  localparam int ELAP_W = 32;
  localparam int WGT_W  = 16;
  localparam int CIDX_W = 8;
  localparam int CDAT_W = 16;

  localparam logic [CIDX_W-1:0] REG_FADE_DURATION   = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_SOURCE_COUNT    = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] REG_CONNECTED_MASK  = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] REG_SWITCHER_ENABLE = CIDX_W'(3);

  localparam logic [DUR_W-1:0]  RST_FADE_DURATION  = DUR_W'(200);
  localparam logic [SLOT_W-1:0] RST_SOURCE_COUNT   = SLOT_W'(2);
  localparam logic [MASK_W-1:0] RST_CONNECTED_MASK = MASK_W'(3);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DECIDE,
    ST_RESOLVE,
    ST_DIVIDE,
    ST_SQUARE,
    ST_CUBE,
    ST_FINISH,
    ST_EMIT
  } xfsc_state_e;

  typedef struct packed {
    logic load;
    logic accum;
    logic decide;
    logic resolve;
    logic div_step;
    logic square;
    logic cube;
    logic finish;
    logic emit;
  } xfsc_cmd_t;

  typedef struct packed {
    logic active;
    logic forward;
    logic blend;
    logic div_last;
  } xfsc_sts_t;

  // mask bit lookup, indexes past the mask read as zero
  function automatic logic bit_of(input logic [MASK_W-1:0] mask, input logic [SLOT_W-1:0] idx);
    logic res;
    res = 1'b0;
    if (int'(idx) < MASK_W) begin
      res = mask[idx];
    end
    return res;
  endfunction

  // physical source of a slot: nearest wired slot at or below, else nearest above
  function automatic logic [SLOT_W-1:0] phys_of(input logic [SLOT_W-1:0] k,
                                                input logic [SLOT_W:0]   n,
                                                input logic [MASK_W-1:0] conn);
    logic [SLOT_W-1:0] lo;
    logic [SLOT_W-1:0] hi;
    logic              lo_ok;
    logic [SLOT_W:0]   iv;
    lo    = '0;
    hi    = '0;
    lo_ok = 1'b0;
    for (int i = 0; i < SLOT_N; i++) begin
      iv = (SLOT_W+1)'(i);
      if (iv <= {1'b0, k} && iv < n && bit_of(conn, iv[SLOT_W-1:0])) begin
        lo    = iv[SLOT_W-1:0];
        lo_ok = 1'b1;
      end
    end
    for (int i = SLOT_N - 1; i >= 0; i--) begin
      iv = (SLOT_W+1)'(i);
      if (iv >= {1'b0, k} && iv < n && bit_of(conn, iv[SLOT_W-1:0])) begin
        hi = iv[SLOT_W-1:0];
      end
    end
    return lo_ok ? lo : hi;
  endfunction

endpackage
`default_nettype wire

FILE: src/xfsc_channels.sv
// handshake channel interfaces: frame input, result output, register write
`timescale 1ns / 1ps
`default_nettype none
interface xfsc_in_if import xfsc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TICK_W-1:0]       tick_delta;
  logic signed [REQ_W-1:0] requested_index;
  logic [MASK_W-1:0]       present_mask;

  modport source (output valid, tick_delta, requested_index, present_mask, input ready);
  modport sink   (input valid, tick_delta, requested_index, present_mask, output ready);
endinterface

interface xfsc_out_if import xfsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] from_source;
  logic [SLOT_W-1:0] to_source;
  logic [WGT_W-1:0]  blend_weight;
  logic              blending;

  modport source (output valid, from_source, to_source, blend_weight, blending, input ready);
  modport sink   (input valid, from_source, to_source, blend_weight, blending, output ready);
endinterface

interface xfsc_cfg_if import xfsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/crossfade_switch_controller.sv
// top level of the crossfade switch controller
// a new frame is accepted only once the previous one is finished, with or without a result
// the blend path runs the 16-step restoring divider and the two-stage cubic multiply
// reset (rst_ni low, async): registers return to duration 200, count 2, mask 3, enabled,
// and the switcher forgets its slots and elapsed time
`timescale 1ns / 1ps
`default_nettype none
module crossfade_switch_controller import xfsc_pkg::*; #(
  parameter int MAX_SOURCES = 12
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  xfsc_in_if.sink     frame_i,
  xfsc_out_if.source  result_o,
  xfsc_cfg_if.sink    cfg_i
);

  xfsc_cmd_t cmd;
  xfsc_sts_t sts;

  // register writes always land, the block is idle by contract
  assign cfg_i.ready = 1'b1;

  // sequencer: one frame transaction at a time, result held in an output register
  xfsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_i.valid),
    .in_ready_o  (frame_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // slot state, fade rules, divider and easing
  xfsc_datapath #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .tick_delta_i      (frame_i.tick_delta),
    .requested_index_i (frame_i.requested_index),
    .present_mask_i    (frame_i.present_mask),
    .from_source_o     (result_o.from_source),
    .to_source_o       (result_o.to_source),
    .blend_weight_o    (result_o.blend_weight),
    .blending_o        (result_o.blending)
  );

  // a frame transaction makes the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i.valid && frame_i.ready |=> !frame_i.ready)
    else $error("frame accepted while busy");

  // a result is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!result_o.valid || result_o.ready))
    else $error("output register overwritten");

  // the sequencer issues at most one datapath command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.accum, cmd.decide, cmd.resolve, cmd.div_step,
              cmd.square, cmd.cube, cmd.finish, cmd.emit}))
    else $error("overlapping datapath commands");

  // divider steps run only while the frame channel is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !frame_i.ready)
    else $error("frame channel open during division");

endmodule
`default_nettype wire

FILE: src/xfsc_ctrl.sv
// sequencing state machine of the crossfade switch controller
`timescale 1ns / 1ps
`default_nettype none
module xfsc_ctrl import xfsc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  input  wire xfsc_sts_t sts_i,
  output xfsc_cmd_t      cmd_o
);

  xfsc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_ACCUM;
      ST_ACCUM:   state_d = sts_i.active ? ST_DECIDE : ST_IDLE;
      ST_DECIDE:  state_d = ST_RESOLVE;
      ST_RESOLVE: begin
        if (sts_i.forward) begin
          state_d = ST_EMIT;
        end else if (sts_i.blend) begin
          state_d = ST_DIVIDE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVIDE:  if (sts_i.div_last) state_d = ST_SQUARE;
      ST_SQUARE:  state_d = ST_CUBE;
      ST_CUBE:    state_d = ST_FINISH;
      ST_FINISH:  state_d = ST_EMIT;
      ST_EMIT:    if (slot_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_ACCUM:   cmd_o.accum    = sts_i.active;
      ST_DECIDE:  cmd_o.decide   = 1'b1;
      ST_RESOLVE: cmd_o.resolve  = 1'b1;
      ST_DIVIDE:  cmd_o.div_step = 1'b1;
      ST_SQUARE:  cmd_o.square   = 1'b1;
      ST_CUBE:    cmd_o.cube     = 1'b1;
      ST_FINISH:  cmd_o.finish   = 1'b1;
      ST_EMIT:    cmd_o.emit     = slot_free;
      default:    cmd_o          = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: src/xfsc_datapath.sv
// registers, transition rules, serial divider and cubic easing of the switcher
`timescale 1ns / 1ps
`default_nettype none
module xfsc_datapath import xfsc_pkg::*; #(
  parameter int MAX_SOURCES = 12
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire xfsc_cmd_t               cmd_i,
  output xfsc_sts_t                    sts_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CIDX_W-1:0]       cfg_index_i,
  input  wire logic [CDAT_W-1:0]       cfg_data_i,
  input  wire logic [TICK_W-1:0]       tick_delta_i,
  input  wire logic signed [REQ_W-1:0] requested_index_i,
  input  wire logic [MASK_W-1:0]       present_mask_i,
  output logic [SLOT_W-1:0]            from_source_o,
  output logic [SLOT_W-1:0]            to_source_o,
  output logic [WGT_W-1:0]             blend_weight_o,
  output logic                         blending_o
);

  localparam logic [SLOT_W:0] MaxN = (SLOT_W+1)'(MAX_SOURCES);

  // configuration
  logic [DUR_W-1:0]  dur_q;
  logic [SLOT_W-1:0] cnt_q;
  logic [MASK_W-1:0] conn_q;
  logic              en_q;

  // frame fields
  logic [TICK_W-1:0]       tick_q;
  logic signed [REQ_W-1:0] req_q;
  logic [MASK_W-1:0]       pres_q;

  // switcher state
  logic [SLOT_W-1:0] tgt_q, tgt_d;
  logic [SLOT_W-1:0] org_q, org_d;
  logic              vld_q, vld_d;
  logic [ELAP_W-1:0] elap_q, elap_d;

  // divider and easing
  logic [DUR_W-1:0]   rem_q;
  logic [WGT_W-1:0]   quo_q;
  logic [SLOT_W-1:0]  dcnt_q;
  logic [WGT_W-1:0]   v_q;
  logic               side_q;
  logic [2*WGT_W-1:0] sq_q;
  logic [3*WGT_W-1:0] cube_q;

  // pending result and output register
  logic [SLOT_W-1:0] res_from_q, res_to_q;
  logic [WGT_W-1:0]  res_w_q;
  logic              res_blend_q;
  logic [SLOT_W-1:0] out_from_q, out_to_q;
  logic [WGT_W-1:0]  out_w_q;
  logic              out_blend_q;

  logic [SLOT_W:0]   n;
  logic [SLOT_W-1:0] n_m1;
  logic [MASK_W-1:0] slot_mask;
  logic [REQ_W-2:0]  req_pos;
  logic [SLOT_W-1:0] dst;
  logic [SLOT_W-1:0] t0, o0;
  logic [ELAP_W:0]   sum;
  logic [ELAP_W-1:0] dur_ext;
  logic [ELAP_W-1:0] e_new;
  logic [SLOT_W-1:0] t_new, o_new;
  logic [SLOT_W-1:0] ph_from, ph_to, from_slot;
  logic              same, to_pres;
  logic [DUR_W:0]    r2;
  logic              ge;
  logic [WGT_W-1:0]  v;
  logic [3*WGT_W+1:0] rnd;
  logic [WGT_W:0]    term;
  logic [WGT_W-1:0]  weight;

  // slots in use (source count capped at MAX_SOURCES) and the mask of slots in use
  always_comb begin
    n    = ({1'b0, cnt_q} > MaxN) ? MaxN : {1'b0, cnt_q};
    n_m1 = SLOT_W'(n - (SLOT_W+1)'(1));
    for (int i = 0; i < MASK_W; i++) begin
      slot_mask[i] = ((SLOT_W+1)'(i) < n);
    end
  end

  // clamped request
  always_comb begin
    req_pos = req_q[REQ_W-1] ? '0 : req_q[REQ_W-2:0];
    dst     = (req_pos > (REQ_W-1)'(n_m1)) ? n_m1 : SLOT_W'(req_pos);
  end

  // first use, slot clamping and saturating elapsed time
  always_comb begin
    t0  = vld_q ? tgt_q : dst;
    o0  = vld_q ? org_q : dst;
    t0  = (t0 > n_m1) ? n_m1 : t0;
    o0  = (o0 > n_m1) ? n_m1 : o0;
    sum = {1'b0, elap_q} + (ELAP_W+1)'(tick_q);
  end

  // reverse, retarget or fresh fade
  always_comb begin
    dur_ext = ELAP_W'(dur_q);
    t_new   = tgt_q;
    o_new   = org_q;
    e_new   = elap_q;
    if (dst != tgt_q) begin
      if (dst == org_q) begin
        o_new = tgt_q;
        t_new = dst;
        e_new = (elap_q >= dur_ext) ? '0 : dur_ext - elap_q;
      end else if ({elap_q, 1'b0} < {1'b0, dur_ext}) begin
        t_new = dst;
      end else begin
        e_new = '0;
        o_new = tgt_q;
        t_new = dst;
      end
    end
    if (e_new >= dur_ext) begin
      o_new = t_new;
    end
  end

  // physical sources and presence
  always_comb begin
    ph_from   = phys_of(org_q, n, conn_q);
    ph_to     = phys_of(tgt_q, n, conn_q);
    from_slot = bit_of(pres_q, ph_from) ? org_q : tgt_q;
    same      = (from_slot == tgt_q);
    to_pres   = bit_of(pres_q, ph_to);
  end

  // restoring division step and easing arithmetic
  always_comb begin
    r2     = {rem_q, 1'b0};
    ge     = (r2 >= {1'b0, dur_q});
    v      = quo_q[WGT_W-1] ? WGT_W'(17'h10000 - {1'b0, quo_q}) : quo_q;
    rnd    = {cube_q, 2'b00} + (3*WGT_W+2)'(64'h8000_0000);
    term   = rnd[3*WGT_W:2*WGT_W];
    if (side_q) begin
      weight = (term == '0) ? '1 : WGT_W'(17'h10000 - term);
    end else begin
      weight = term[WGT_W-1:0];
    end
  end

  always_comb begin
    sts_o.active   = en_q && (n != '0) && |(conn_q & slot_mask);
    sts_o.forward  = same && to_pres;
    sts_o.blend    = !same && to_pres;
    sts_o.div_last = (dcnt_q == '1);
  end

  always_comb begin
    tgt_d  = tgt_q;
    org_d  = org_q;
    vld_d  = vld_q;
    elap_d = elap_q;
    if (cmd_i.accum) begin
      tgt_d  = t0;
      org_d  = o0;
      vld_d  = 1'b1;
      elap_d = sum[ELAP_W] ? '1 : sum[ELAP_W-1:0];
    end else if (cmd_i.decide) begin
      tgt_d  = t_new;
      org_d  = o_new;
      elap_d = e_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q  <= RST_FADE_DURATION;
      cnt_q  <= RST_SOURCE_COUNT;
      conn_q <= RST_CONNECTED_MASK;
      en_q   <= 1'b1;
      tgt_q  <= '0;
      org_q  <= '0;
      vld_q  <= 1'b0;
      elap_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FADE_DURATION:   dur_q  <= cfg_data_i[DUR_W-1:0];
          REG_SOURCE_COUNT:    cnt_q  <= cfg_data_i[SLOT_W-1:0];
          REG_CONNECTED_MASK:  conn_q <= cfg_data_i[MASK_W-1:0];
          REG_SWITCHER_ENABLE: en_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      tgt_q  <= tgt_d;
      org_q  <= org_d;
      vld_q  <= vld_d;
      elap_q <= elap_d;
      if (cmd_i.resolve) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tick_q <= tick_delta_i;
      req_q  <= requested_index_i;
      pres_q <= present_mask_i;
    end
    if (cmd_i.resolve) begin
      res_from_q  <= same ? ph_to : ph_from;
      res_to_q    <= ph_to;
      res_w_q     <= '1;
      res_blend_q <= !same;
      rem_q       <= elap_q[DUR_W-1:0];
      quo_q       <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? DUR_W'(r2 - {1'b0, dur_q}) : r2[DUR_W-1:0];
      quo_q <= {quo_q[WGT_W-2:0], ge};
    end
    if (cmd_i.square) begin
      v_q    <= v;
      side_q <= quo_q[WGT_W-1];
      sq_q   <= v * v;
    end
    if (cmd_i.cube) begin
      cube_q <= sq_q * v_q;
    end
    if (cmd_i.finish) begin
      res_w_q <= weight;
    end
    if (cmd_i.emit) begin
      out_from_q  <= res_from_q;
      out_to_q    <= res_to_q;
      out_w_q     <= res_w_q;
      out_blend_q <= res_blend_q;
    end
  end

  assign from_source_o  = out_from_q;
  assign to_source_o    = out_to_q;
  assign blend_weight_o = out_w_q;
  assign blending_o     = out_blend_q;

endmodule
`default_nettype wire
